@@ rtl/token_bucket_delay_calc_unit_defines.svh @@
// Assertion macros for the token bucket delay calculator.
`ifndef TOKEN_BUCKET_DELAY_CALC_UNIT_DEFINES_SVH
`define TOKEN_BUCKET_DELAY_CALC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising edge, skipped while reset is high.
`define TBDC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tbdc assertion failed");
// Checked at every rising edge, reset included.
`define TBDC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("tbdc assertion failed");
`else
`define TBDC_ASSERT(label, prop)
`define TBDC_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ rtl/tbdc_pkg.sv @@
// Shared widths, constants and types of the token bucket delay calculator.
`default_nettype none

package tbdc_pkg;

   localparam int DATA_W      = 32;            // rate, cost, time
   localparam int BUDGET_W    = 64;            // signed token budget
   localparam int DELAY_W     = 31;            // result width
   localparam int ALU_W       = 76;            // shared adder, signed
   localparam int MS_SHIFT    = 3;             // 1000 = 5 * 5 * 5 << 3
   localparam int SCALE_STEPS = 3;             // times-five passes
   localparam int SCALED_W    = BUDGET_W + 7;  // neg * 125 fits here
   localparam int DIV_STEPS   = DELAY_W;       // one quotient bit a pass
   localparam int HIGH_LSB    = DIV_STEPS - MS_SHIFT;
   localparam int CNT_W       = $clog2(DIV_STEPS);

   localparam logic [DATA_W-1:0]   RATE_RESET = DATA_W'(1);
   localparam logic [DELAY_W-1:0]  DELAY_MAX  = {DELAY_W{1'b1}};
   localparam logic [BUDGET_W-1:0] BUDGET_MIN = {1'b1, {(BUDGET_W-1){1'b0}}};

   typedef logic [ALU_W-1:0] alu_word_type;

endpackage

`default_nettype wire

@@ rtl/token_bucket_delay_calc_unit.sv @@
// Token bucket rate limiter that returns the wait in milliseconds per request.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  req     | in        | req_valid / req_stall      | req_request_cost, req_now_seconds
//  rsp     | out       | rsp_valid / rsp_stall      | rsp_delay_ms
//  csr     | in        | csr_valid / csr_ready      | csr_refill_rate
//
//  Items are taken one at a time: the next is accepted once the last leaves FINISH.
//  The longest step is the 31-pass restoring divider, which shares the one 76-bit
//  adder with the refill, cost and scale steps. An item with a nonnegative budget
//  skips the scale and divide steps.
//  Reset: synchronous, active high; clears state, sets refill_rate to 1,
//  budget and last refill time to zero.
//  Stalls: the result register frees the input side; a new item is taken while
//  the last result waits. A finished item waits in FINISH if rsp is still full.
//  csr is ready only while no item is in flight and none is offered.
`default_nettype none

`include "token_bucket_delay_calc_unit_defines.svh"

module token_bucket_delay_calc_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [tbdc_pkg::DATA_W-1:0]  req_request_cost,
   input  wire logic [tbdc_pkg::DATA_W-1:0]  req_now_seconds,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [tbdc_pkg::DELAY_W-1:0]      rsp_delay_ms,
   // refill rate register write
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [tbdc_pkg::DATA_W-1:0]  csr_refill_rate
);

   typedef enum logic [3:0] {
      ST_IDLE,    // wait for an item
      ST_MUL,     // gain = elapsed * rate
      ST_NEED,    // need = rate - budget
      ST_GAIN,    // gain - need
      ST_ADDG,    // budget = rate + (gain - need)
      ST_COST,    // budget - cost, saturating
      ST_NEGATE,  // neg = -budget
      ST_SCALE,   // neg * 125, three times-five passes
      ST_CHECK,   // quotient overflow test
      ST_DIV,     // restoring divide, one bit a pass
      ST_FINISH   // hand result to the output register
   } state_type;

   localparam int AW = tbdc_pkg::ALU_W;
   localparam int BW = tbdc_pkg::BUDGET_W;
   localparam int DW = tbdc_pkg::DATA_W;
   localparam int QW = tbdc_pkg::DELAY_W;

   state_type                       state_ff;
   logic [DW-1:0]                   rate_ff;
   logic [BW-1:0]                   budget_ff;
   logic [DW-1:0]                   last_ff;
   logic [DW-1:0]                   cost_ff;
   logic [DW-1:0]                   now_ff;
   logic [DW-1:0]                   elapsed_ff;
   logic                            refill_ff;
   logic [BW-1:0]                   gain_ff;
   tbdc_pkg::alu_word_type          acc_ff;
   logic [DW-1:0]                   rem_ff;
   logic [QW-1:0]                   qsh_ff;
   logic [tbdc_pkg::CNT_W-1:0]      cnt_ff;
   logic [QW-1:0]                   res_ff;
   logic                            rsp_valid_ff;
   logic [QW-1:0]                   rsp_delay_ff;

   // shared adder
   tbdc_pkg::alu_word_type alu_a;
   tbdc_pkg::alu_word_type alu_b;
   logic                   alu_sub;
   tbdc_pkg::alu_word_type alu_y;
   logic                   alu_neg;

   tbdc_pkg::alu_word_type rate_x;
   tbdc_pkg::alu_word_type budget_x;
   logic [DW:0]            div_trial;
   logic                   qbit;
   logic                   cost_sat;
   logic                   req_take;
   logic                   rsp_free;

   assign rate_x    = {{(AW-DW){1'b0}}, rate_ff};
   assign budget_x  = {{(AW-BW){budget_ff[BW-1]}}, budget_ff};
   assign div_trial = {rem_ff, qsh_ff[QW-1]};

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      unique case (state_ff)
         ST_NEED: begin
            alu_a = rate_x;
            alu_b = budget_x;
         end
         ST_GAIN: begin
            alu_a = {{(AW-BW){1'b0}}, gain_ff};
            alu_b = acc_ff;
         end
         ST_ADDG: begin
            alu_a   = rate_x;
            alu_b   = acc_ff;
            alu_sub = 1'b0;
         end
         ST_COST: begin
            alu_a = budget_x;
            alu_b = {{(AW-DW){1'b0}}, cost_ff};
         end
         ST_NEGATE: begin
            alu_b = budget_x;
         end
         ST_SCALE: begin
            alu_a   = {acc_ff[AW-3:0], 2'b00};
            alu_b   = acc_ff;
            alu_sub = 1'b0;
         end
         ST_CHECK: begin
            alu_a = {{(AW-(tbdc_pkg::SCALED_W-tbdc_pkg::HIGH_LSB)){1'b0}},
                     acc_ff[tbdc_pkg::SCALED_W-1:tbdc_pkg::HIGH_LSB]};
            alu_b = rate_x;
         end
         ST_DIV: begin
            alu_a = {{(AW-DW-1){1'b0}}, div_trial};
            alu_b = rate_x;
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b1;
         end
      endcase
   end

   assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_neg = alu_y[AW-1];
   // below -2^63 when the sign bit disagrees with any bit down to bit 63
   assign cost_sat = alu_neg && !(&alu_y[AW-1:BW-1]);
   assign qbit     = !alu_neg;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= tbdc_pkg::RATE_RESET;
         budget_ff    <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register: load from FINISH, else drop once taken
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            rate_ff <= csr_refill_rate;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  cost_ff    <= req_request_cost;
                  now_ff     <= req_now_seconds;
                  elapsed_ff <= req_now_seconds - last_ff;
                  refill_ff  <= req_now_seconds > last_ff;
                  state_ff   <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (refill_ff) begin
                  gain_ff  <= {{(BW-DW){1'b0}}, elapsed_ff} * {{(BW-DW){1'b0}}, rate_ff};
                  last_ff  <= now_ff;
                  state_ff <= ST_NEED;
               end else begin
                  state_ff <= ST_COST;
               end
            end
            ST_NEED: begin
               acc_ff <= alu_y;
               if (alu_neg || alu_y == '0) begin
                  budget_ff <= {{(BW-DW){1'b0}}, rate_ff};
                  state_ff  <= ST_COST;
               end else begin
                  state_ff <= ST_GAIN;
               end
            end
            ST_GAIN: begin
               acc_ff <= alu_y;
               if (!alu_neg) begin
                  budget_ff <= {{(BW-DW){1'b0}}, rate_ff};
                  state_ff  <= ST_COST;
               end else begin
                  state_ff <= ST_ADDG;
               end
            end
            ST_ADDG: begin
               budget_ff <= alu_y[BW-1:0];
               state_ff  <= ST_COST;
            end
            ST_COST: begin
               budget_ff <= cost_sat ? tbdc_pkg::BUDGET_MIN : alu_y[BW-1:0];
               state_ff  <= ST_NEGATE;
            end
            ST_NEGATE: begin
               if (!budget_ff[BW-1]) begin
                  res_ff   <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  acc_ff   <= alu_y;
                  cnt_ff   <= '0;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               acc_ff <= alu_y;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == tbdc_pkg::CNT_W'(tbdc_pkg::SCALE_STEPS - 1)) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               // N = acc * 8; quotient fits when N >> 31 is below the rate
               if (!alu_neg) begin
                  res_ff   <= tbdc_pkg::DELAY_MAX;
                  state_ff <= ST_FINISH;
               end else begin
                  rem_ff   <= acc_ff[tbdc_pkg::HIGH_LSB+DW-1:tbdc_pkg::HIGH_LSB];
                  qsh_ff   <= {acc_ff[tbdc_pkg::HIGH_LSB-1:0],
                               {tbdc_pkg::MS_SHIFT{1'b0}}};
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= qbit ? alu_y[DW-1:0] : div_trial[DW-1:0];
               qsh_ff <= {qsh_ff[QW-2:0], qbit};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == tbdc_pkg::CNT_W'(tbdc_pkg::DIV_STEPS - 1)) begin
                  res_ff   <= {qsh_ff[QW-2:0], qbit};
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_delay_ff <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall    = state_ff != ST_IDLE;
   // no rate change in the edge that takes an item
   assign csr_ready    = (state_ff == ST_IDLE) && !req_valid;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_delay_ms = rsp_delay_ff;

   // a result only appears from the hand-off step
   `TBDC_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
   // divider remainder stays below the divisor
   `TBDC_ASSERT(a_div_rem_bound, (state_ff == ST_DIV) |-> (rem_ff < rate_ff))
   // partial refill only when gain fell short of the need
   `TBDC_ASSERT(a_addg_short, (state_ff == ST_ADDG) |-> acc_ff[AW-1])
   // an accepted item always starts the sequencer
   `TBDC_ASSERT(a_take_starts, req_take |=> (state_ff == ST_MUL))

endmodule

`default_nettype wire

@@ sim/tb_token_bucket_delay_calc_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the token bucket delay calculator: predicted waits vs results.
module tb_token_bucket_delay_calc_unit;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;  // watchdog, many times the slowest run
   localparam int unsigned DRAIN_CYCLES    = 60;         // above the worst per-item latency
   localparam int unsigned ITEMS_PER_PHASE = 185;

   // Tracks the bucket (rate, signed budget, last refill second) and the waits still owed.
   class bucket_delay_checker;
      localparam logic [tbdc_pkg::BUDGET_W-1:0] MS_PER_S = tbdc_pkg::BUDGET_W'(1000);

      logic [tbdc_pkg::DATA_W-1:0]          rate        = tbdc_pkg::RATE_RESET;
      logic signed [tbdc_pkg::BUDGET_W-1:0] budget      = '0;
      logic [tbdc_pkg::DATA_W-1:0]          last_refill = '0;
      logic [tbdc_pkg::DELAY_W-1:0]         owed_delays[$];
      int unsigned                          requests, checked, nonzero, saturated, errors;

      function void set_rate(logic [tbdc_pkg::DATA_W-1:0] value);
         rate = value;
      endfunction

      // Whole-second refill, capped at the rate; time at or before the last refill is a no-op.
      function void refill(logic [tbdc_pkg::DATA_W-1:0] now);
         logic [tbdc_pkg::DATA_W-1:0]   elapsed;
         logic [tbdc_pkg::BUDGET_W-1:0] cap, gain, need;
         if (now <= last_refill) return;
         elapsed     = now - last_refill;
         cap         = tbdc_pkg::BUDGET_W'(rate);
         gain        = tbdc_pkg::BUDGET_W'(elapsed) * cap;   // exact: 32 x 32 fits 64
         last_refill = now;
         if (budget >= $signed(cap)) begin
            // over capacity after the rate was lowered
            budget = cap;
            return;
         end
         need = cap - budget;
         if (gain >= need) budget = cap;
         else budget = budget + gain;
      endfunction

      // Subtract the cost, saturating at the most negative budget.
      function void spend(logic [tbdc_pkg::DATA_W-1:0] cost);
         logic signed [tbdc_pkg::BUDGET_W:0] diff;
         diff = {budget[tbdc_pkg::BUDGET_W-1], budget}
                - {1'b0, tbdc_pkg::BUDGET_W'(cost)};
         if (diff[tbdc_pkg::BUDGET_W] != diff[tbdc_pkg::BUDGET_W-1]) begin
            budget = tbdc_pkg::BUDGET_MIN;
         end else begin
            budget = diff[tbdc_pkg::BUDGET_W-1:0];
         end
      endfunction

      // -budget * 1000 / rate, rounded down, saturating; zero rate means the longest wait.
      function logic [tbdc_pkg::DELAY_W-1:0] predict_delay();
         logic [tbdc_pkg::BUDGET_W-1:0] mag, cap, q, r, d;
         if (budget >= 0) return '0;
         if (rate == '0) return tbdc_pkg::DELAY_MAX;
         cap = tbdc_pkg::BUDGET_W'(rate);
         mag = '0 - budget;
         q   = mag / cap;
         r   = mag % cap;
         if (q > tbdc_pkg::BUDGET_W'(tbdc_pkg::DELAY_MAX)) return tbdc_pkg::DELAY_MAX;
         d = q * MS_PER_S + (r * MS_PER_S) / cap;
         if (d > tbdc_pkg::BUDGET_W'(tbdc_pkg::DELAY_MAX)) return tbdc_pkg::DELAY_MAX;
         return d[tbdc_pkg::DELAY_W-1:0];
      endfunction

      function void note_request(logic [tbdc_pkg::DATA_W-1:0] cost,
                                 logic [tbdc_pkg::DATA_W-1:0] now);
         logic [tbdc_pkg::DELAY_W-1:0] delay;
         refill(now);
         spend(cost);
         delay = predict_delay();
         owed_delays.push_back(delay);
         requests++;
         if (delay != '0) nonzero++;
         if (delay == tbdc_pkg::DELAY_MAX) saturated++;
      endfunction

      function void check_delay(logic [tbdc_pkg::DELAY_W-1:0] actual);
         logic [tbdc_pkg::DELAY_W-1:0] expected;
         if (owed_delays.size() == 0) begin
            $error("delay_ms: item with none owed, expected none, actual %0d", actual);
            errors++;
            return;
         end
         expected = owed_delays.pop_front();
         checked++;
         if (actual !== expected) begin
            $error("delay_ms mismatch: expected %0d, actual %0d", expected, actual);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return owed_delays.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [tbdc_pkg::DATA_W-1:0]   req_request_cost;
   logic [tbdc_pkg::DATA_W-1:0]   req_now_seconds;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [tbdc_pkg::DELAY_W-1:0]  rsp_delay_ms;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [tbdc_pkg::DATA_W-1:0]   csr_refill_rate;

   bucket_delay_checker           ledger = new();
   bit                            steady = 1'b0;   // no gaps, no stalls while set
   logic [tbdc_pkg::DATA_W-1:0]   wall_s;          // running time base in seconds
   int unsigned                   rate_settings;

   token_bucket_delay_calc_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_request_cost (req_request_cost),
      .req_now_seconds  (req_now_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_delay_ms     (rsp_delay_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_refill_rate  (csr_refill_rate)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hang guard.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // Saturating advance of the time base, so it never wraps below the last refill.
   function automatic logic [tbdc_pkg::DATA_W-1:0] later(logic [tbdc_pkg::DATA_W-1:0] base,
                                                         int unsigned step);
      return (base > '1 - step) ? '1 : base + step;
   endfunction

   // Drive one request item; handshake is sampled mid-cycle so edge ordering cannot matter.
   task automatic send_request(input logic [tbdc_pkg::DATA_W-1:0] cost,
                               input logic [tbdc_pkg::DATA_W-1:0] now);
      bit          taken;
      int unsigned gap;
      gap = 0;
      while (!steady && $urandom_range(0, 99) < 20) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_request_cost <= cost;
      req_now_seconds  <= now;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      ledger.note_request(cost, now);
   endtask

   // Rate writes only once every owed wait has come back; csr_ready covers the rest.
   task automatic write_refill_rate(input logic [tbdc_pkg::DATA_W-1:0] value);
      bit taken;
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_refill_rate <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      ledger.set_rate(value);
      rate_settings++;
   endtask

   // Mostly forward time in small steps with costs around the rate; some stale times,
   // long jumps that refill a deep deficit, and full-range costs.
   task automatic random_request();
      logic [tbdc_pkg::DATA_W-1:0] cost, now, rate;
      int unsigned                 pick;
      rate = ledger.rate;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         now = $urandom_range(0, wall_s);   // at or before the time base
      end else begin
         if (pick < 60) wall_s = later(wall_s, $urandom_range(0, 1));
         else if (pick < 88) wall_s = later(wall_s, $urandom_range(2, 20));
         else wall_s = later(wall_s, $urandom_range(21, 100000));
         now = wall_s;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) cost = '0;
      else if (pick < 14) cost = $urandom >> $urandom_range(0, 31);
      else if (pick < 17) cost = $urandom;
      else if (pick < 19) cost = '1;
      else if (rate == '0) cost = $urandom_range(0, 3);
      else if (rate > 32'h7FFF_FFFF) cost = $urandom;
      else cost = $urandom_range(0, 2 * rate);
      send_request(cost, now);
   endtask

   task automatic run_phase(input logic [tbdc_pkg::DATA_W-1:0] rate, input bit no_gaps);
      write_refill_rate(rate);
      steady = no_gaps;
      repeat (ITEMS_PER_PHASE) random_request();
      steady = 1'b0;
   endtask

   // Result side: random stalls, check on every accepted item.
   initial begin
      bit                           taken;
      logic [tbdc_pkg::DELAY_W-1:0] delay;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         taken = !reset && rsp_valid && !rsp_stall;
         delay = rsp_delay_ms;
         @(posedge clock);
         if (taken) ledger.check_delay(delay);
         rsp_stall <= !steady && ($urandom_range(0, 99) < 20);
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_request_cost <= '0;
      req_now_seconds  <= '0;
      csr_valid        <= 1'b0;
      csr_refill_rate  <= '0;
      wall_s           = '0;
      rate_settings    = 1;   // the reset rate counts as one
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset rate of one token per second ---
      send_request('0, '0);               // same time as reset, nothing owed
      send_request(32'd1, '0);            // one token short: one second
      send_request('0, 32'd1);            // refill back to zero
      send_request('1, 32'd1);            // maximum cost: wait saturates
      send_request('0, '0);               // earlier time: no refill
      send_request('0, 32'd3);            // partial refill of a deep deficit

      // --- largest rate: huge refill product, sub-millisecond waits ---
      write_refill_rate('1);
      send_request('0, 32'd1000000);      // elapsed * rate far above capacity
      send_request('1, 32'd1000000);      // budget back to zero
      send_request(32'd1, 32'd1000000);   // rounds down to zero ms
      send_request('1, 32'd1000000);      // just over one second short: 1000 ms
      send_request('0, 32'd1000001);

      // --- zero rate with the budget still in deficit ---
      write_refill_rate('0);
      send_request(32'd5, 32'd1000001);   // no refill: the deficit grows
      send_request('0, 32'd1000002);      // refill adds nothing to the deficit
      send_request(32'd1, 32'd1000002);   // negative with zero rate: longest wait
      send_request('0, 32'd1000010);      // refill gains nothing

      // --- ordinary rate ---
      write_refill_rate(32'd1000);
      send_request(32'd500, 32'd1000011);
      send_request(32'd2000, 32'd1000011);
      wall_s = 32'd1000011;

      // --- random phases across the rate range, one of them without gaps or stalls ---
      run_phase(32'd1000, 1'b0);
      run_phase(32'd1, 1'b0);
      run_phase($urandom_range(2, 100), 1'b1);
      run_phase('0, 1'b0);
      run_phase('1, 1'b0);
      run_phase($urandom, 1'b0);
      run_phase($urandom_range(100, 100000), 1'b0);
      // high half of the time range, ending at the last second there is
      wall_s = $urandom_range(32'h8000_0000, 32'hFFF0_0000);
      run_phase($urandom_range(1, 50000), 1'b0);
      send_request($urandom, '1);

      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests over %0d refill rate settings, time up to %0d s.",
               ledger.requests, rate_settings, wall_s);
      $display("Checked %0d waits: %0d nonzero, %0d saturated, %0d mismatches.",
               ledger.checked, ledger.nonzero, ledger.saturated, ledger.errors);
      if (ledger.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ token_bucket_delay_calc_unit.f @@
+incdir+rtl
rtl/tbdc_pkg.sv
rtl/token_bucket_delay_calc_unit.sv
sim/tb_token_bucket_delay_calc_unit.sv
